>>> design/ffsa_pkg.sv
// Package for the first-fit segment allocator.
// Holds the opcode and status codes shared by the top level and its users.
`timescale 1ns / 1ps

package ffsa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_LIMIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

endpackage

>>> design/first_fit_segment_allocator_unit.sv
// First-fit segment allocator, top level. Uses ffsa_pkg and ffsa_seg_ram.
// Sequencer that walks the segment table held in a synchronous memory.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Its single result
// item appears at the end of the walk, marked by a one-cycle done pulse, and
// the receiver cannot hold it off. Every table read goes through the one
// read port of the segment table, which registers its data, so each table
// entry visited takes a read state and then a check state. An allocate
// walks the entries from the first until it finds the first fitting entry i.
// A split then shifts the entries above i up by one, from the end down,
// and then writes the remainder and the allocated entry. An append is done
// after a walk over the whole table, or at once on an empty table. A free
// walks to find its entry and then makes a merging pass that rewrites the
// table. Null requests and a free on an empty table are never busy: done
// follows in the cycle after they are taken. No clearing pass is needed
// after reset: only entries below the segment count are ever read.
// PAGE_BYTES must be a power of two.

module first_fit_segment_allocator_unit
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS     = 64,
  parameter int HEADER_BYTES     = 24,
  parameter int PAGE_BYTES       = 4096,
  parameter int HEAP_LIMIT_BYTES = 16777216
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [47:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [24:0] request_size,
  input  logic [47:0] block_address,
  output logic        done,
  output logic [47:0] result_address,
  output logic [2:0]  status,
  output logic [12:0] pages_added
);

  localparam int IW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int LB = $clog2(HEAP_LIMIT_BYTES + 1);
  // Offsets and sizes: wide enough for a rounded request and any sum of them.
  localparam int W  = (LB + 2 > 27) ? LB + 2 : 27;
  localparam int DW = 2 * W + 1;
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam logic [W-1:0] HDR = W'(HEADER_BYTES);
  localparam logic [W-1:0] LIM = W'(HEAP_LIMIT_BYTES);
  localparam logic [W-1:0] PGM = W'(PAGE_BYTES - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_SH_RD    = 4'd3;
  localparam logic [3:0] S_SH_CHK   = 4'd4;
  localparam logic [3:0] S_INS_WR   = 4'd5;
  localparam logic [3:0] S_OWN_WR   = 4'd6;
  localparam logic [3:0] S_APPEND   = 4'd7;
  localparam logic [3:0] S_M_RD     = 4'd8;
  localparam logic [3:0] S_M_CHK    = 4'd9;
  localparam logic [3:0] S_M_END    = 4'd10;

  logic [3:0]    state;
  logic [47:0]   heap_base;
  logic [CW-1:0] seg_count;
  logic [W-1:0]  heap_top;
  logic          op;
  logic [W-1:0]  asize;
  logic [47:0]   addr;
  logic [IW-1:0] idx;
  logic [IW-1:0] hit_idx;
  logic [W-1:0]  hit_off;
  logic [W-1:0]  new_off;
  logic [W-1:0]  new_size;
  logic [W-1:0]  last_end;
  logic [IW-1:0] wptr;
  logic [W-1:0]  cur_off;
  logic [W-1:0]  cur_size;
  logic          cur_free;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] rdata;

  // Fields of the entry just read.
  logic [W-1:0]  rd_off;
  logic [W-1:0]  rd_size;
  logic          rd_free;
  logic          last_idx;
  logic [47:0]   rd_payload;
  logic [W-1:0]  req_asize;
  logic [W-1:0]  app_end;
  logic [W-1:0]  app_grow;
  logic          e_free;

  assign rd_off   = rdata[DW-1 -: W];
  assign rd_size  = rdata[W:1];
  assign rd_free  = rdata[0];
  assign last_idx = ((CW'(idx) + CW'(1)) == seg_count);
  assign rd_payload = heap_base + 48'(rd_off) + 48'(HEADER_BYTES);
  assign req_asize  = (W'(request_size) + W'(3)) & ~W'(3);
  assign app_end    = last_end + HDR + asize;
  // Heap growth rounded up to whole pages.
  assign app_grow   = ((app_end - heap_top) + PGM) & ~PGM;
  assign e_free     = rd_free | (idx == hit_idx);
  assign busy       = (state != S_IDLE);

  ffsa_seg_ram #(
    .DEPTH(MAX_SEGMENTS),
    .AW   (IW),
    .DW   (DW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  // Single write port, steered by the sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {rd_off, rd_size, 1'b0};
    unique case (state)
      S_SCAN_CHK: begin
        // Whole segment handed out without a split.
        mem_we = (op == OP_ALLOC) && rd_free && (rd_size >= asize) &&
                 !((rd_size >= asize + HDR + W'(4)) &&
                   (seg_count < CW'(MAX_SEGMENTS)));
      end
      S_SH_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = idx + IW'(1);
        mem_wdata = rdata;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx + IW'(1);
        mem_wdata = {new_off, new_size, 1'b1};
      end
      S_OWN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx;
        mem_wdata = {hit_off, asize, 1'b0};
      end
      S_APPEND: begin
        mem_we    = (seg_count < CW'(MAX_SEGMENTS)) && (app_end <= LIM);
        mem_waddr = IW'(seg_count);
        mem_wdata = {last_end, asize, 1'b0};
      end
      S_M_CHK: begin
        mem_we    = (idx != '0) && !(cur_free && e_free);
        mem_waddr = wptr;
        mem_wdata = {cur_off, cur_size, cur_free};
      end
      S_M_END: begin
        mem_we    = 1'b1;
        mem_waddr = wptr;
        mem_wdata = {cur_off, cur_size, cur_free};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      heap_base <= 48'h0000_4000_0000;
      seg_count <= '0;
      heap_top  <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        heap_base <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op             <= opcode;
            asize          <= req_asize;
            addr           <= block_address;
            idx            <= '0;
            last_end       <= '0;
            result_address <= '0;
            pages_added    <= '0;
            if ((opcode == OP_ALLOC) && (request_size == '0)) begin
              done   <= 1'b1;
              status <= ST_NULL;
            end else if ((opcode == OP_FREE) && (block_address == '0)) begin
              done   <= 1'b1;
              status <= ST_NULL;
            end else if (seg_count == '0) begin
              if (opcode == OP_ALLOC) begin
                state <= S_APPEND;
              end else begin
                done   <= 1'b1;
                status <= ST_UNKNOWN;
              end
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (op == OP_ALLOC) begin
            last_end <= rd_off + HDR + rd_size;
            if (rd_free && (rd_size >= asize)) begin
              hit_idx        <= idx;
              hit_off        <= rd_off;
              new_off        <= rd_off + HDR + asize;
              new_size       <= rd_size - asize - HDR;
              result_address <= rd_payload;
              status         <= ST_OK;
              if ((rd_size >= asize + HDR + W'(4)) &&
                  (seg_count < CW'(MAX_SEGMENTS))) begin
                if (last_idx) begin
                  state <= S_INS_WR;
                end else begin
                  idx   <= IW'(seg_count - CW'(1));
                  state <= S_SH_RD;
                end
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end else if (last_idx) begin
              state <= S_APPEND;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            if (rd_payload == addr) begin
              hit_idx <= idx;
              idx     <= '0;
              wptr    <= '0;
              state   <= S_M_RD;
            end else if (last_idx) begin
              done   <= 1'b1;
              status <= ST_UNKNOWN;
              state  <= S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_SCAN_RD;
            end
          end
        end
        S_SH_RD: begin
          state <= S_SH_CHK;
        end
        S_SH_CHK: begin
          // Entries move up by one, from the end down to just past the hit.
          if (idx == hit_idx + IW'(1)) begin
            state <= S_INS_WR;
          end else begin
            idx   <= idx - IW'(1);
            state <= S_SH_RD;
          end
        end
        S_INS_WR: begin
          state <= S_OWN_WR;
        end
        S_OWN_WR: begin
          seg_count <= seg_count + CW'(1);
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_APPEND: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (seg_count >= CW'(MAX_SEGMENTS)) begin
            status <= ST_FULL;
          end else if (app_end > LIM) begin
            status <= ST_LIMIT;
          end else begin
            status         <= ST_OK;
            seg_count      <= seg_count + CW'(1);
            result_address <= heap_base + 48'(last_end) + 48'(HEADER_BYTES);
            if (app_end > heap_top) begin
              heap_top    <= heap_top + app_grow;
              pages_added <= 13'(app_grow >> PAGE_SH);
            end
          end
        end
        S_M_RD: begin
          state <= S_M_CHK;
        end
        S_M_CHK: begin
          // Streaming compaction: the freed entry is marked on the fly and
          // runs of free entries fold into the one at their head.
          if (idx == '0) begin
            cur_off  <= rd_off;
            cur_size <= rd_size;
            cur_free <= e_free;
          end else if (cur_free && e_free) begin
            cur_size <= cur_size + HDR + rd_size;
          end else begin
            wptr     <= wptr + IW'(1);
            cur_off  <= rd_off;
            cur_size <= rd_size;
            cur_free <= e_free;
          end
          if (last_idx) begin
            state <= S_M_END;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_M_RD;
          end
        end
        S_M_END: begin
          seg_count <= CW'(wptr) + CW'(1);
          status    <= ST_OK;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/ffsa_seg_ram.sv
// Segment table memory: one write port, one read port with registered data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module ffsa_seg_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 55
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
